// ===== hw/rtl/sfd_pkg.sv =====
// Shared types and constants for the step and fall detector.
`default_nettype none
package sfd_pkg;

	// Fixed field widths
	localparam int TimeBits    = 32;
	localparam int CountBits   = 32;
	localparam int MagBits     = 16;
	localparam int OpndBits    = 16;
	localparam int NumSq       = 7;
	localparam int SqIdxBits   = $clog2(NumSq);
	localparam int RadBits     = 2 * OpndBits;
	localparam int RateBits    = 2 * OpndBits + 2;
	localparam int RootCntBits = $clog2(MagBits);

	// 0.3 g rise, 0.8 g .. 1.2 g stillness band, in raw LSB
	localparam logic [MagBits:0]   RiseLimit = 17'd4915;
	localparam logic [MagBits-1:0] BandLow   = 16'd13108;
	localparam logic [MagBits-1:0] BandHigh  = 16'd19660;

	// Configuration register reset values
	localparam logic [15:0] StepThrRst     = 16'd19661;
	localparam logic [15:0] StepGapRst     = 16'd350;
	localparam logic [15:0] FallAccThrRst  = 16'd52429;
	localparam logic [15:0] FallRateThrRst = 16'd39300;
	localparam logic [15:0] StillRst       = 16'd2000;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_GYRO_OFS_X   = 3'd0,
		REG_GYRO_OFS_Y   = 3'd1,
		REG_GYRO_OFS_Z   = 3'd2,
		REG_STEP_THR     = 3'd3,
		REG_STEP_GAP     = 3'd4,
		REG_FALL_ACC_THR = 3'd5,
		REG_FALL_RATE    = 3'd6,
		REG_STILL        = 3'd7
	} cfg_reg_t;

	// Squaring operands: accel x,y,z, corrected gyro x,y,z, rate threshold
	typedef logic [NumSq-1:0][OpndBits-1:0] sq_ops_t;

	// Results of the squaring pass
	typedef struct packed {
		logic                done;
		logic [RadBits-1:0]  mag_sq;
		logic [RateBits-1:0] rate_sq;
		logic [RadBits-1:0]  rate_lim;
	} sq_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sfd_sqacc.sv =====
// Shared squaring multiplier that accumulates the accel and gyro sums and squares the rate threshold.
`default_nettype none
module sfd_sqacc (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sfd_pkg::sq_ops_t ops,
	output sfd_pkg::sq_res_t     res
);
	import sfd_pkg::*;

	logic                 busy_q;
	logic [SqIdxBits-1:0] cnt_q;
	logic                 pv_q;
	logic [SqIdxBits-1:0] pidx_q;
	logic [RadBits-1:0]   prod_q;
	logic                 done_q;
	logic [RadBits-1:0]   mag_sq_q;
	logic [RateBits-1:0]  rate_sq_q;
	logic [RadBits-1:0]   rate_lim_q;

	// Issue one square per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= pv_q && (pidx_q == SqIdxBits'(NumSq - 1));
			pv_q   <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SqIdxBits'(NumSq - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Product register, then accumulate into the right sum or latch the squared rate threshold
	always_ff @(posedge clk) begin
		prod_q <= ops[cnt_q] * ops[cnt_q];
		pidx_q <= cnt_q;
		if (start) begin
			mag_sq_q  <= '0;
			rate_sq_q <= '0;
		end else if (pv_q) begin
			if (pidx_q < SqIdxBits'(3))
				mag_sq_q <= mag_sq_q + prod_q;
			else if (pidx_q < SqIdxBits'(6))
				rate_sq_q <= rate_sq_q + RateBits'(prod_q);
			else
				rate_lim_q <= prod_q;
		end
	end

	assign res.done     = done_q;
	assign res.mag_sq   = mag_sq_q;
	assign res.rate_sq  = rate_sq_q;
	assign res.rate_lim = rate_lim_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sfd_isqrt.sv =====
// Bit-serial floor square root, two radicand bits per cycle.
`default_nettype none
module sfd_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sfd_pkg::RadBits-1:0] radicand,
	output logic                             done,
	output logic [sfd_pkg::MagBits-1:0]      root
);
	import sfd_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [RootCntBits-1:0] cnt_q;
	logic [RadBits-1:0]     x_q;
	logic [MagBits:0]       rem_q;
	logic [MagBits-1:0]     root_q;
	logic [MagBits+2:0]     rem_next;
	logic [MagBits+2:0]     trial;
	logic                   fits;

	// One restoring step
	always_comb begin
		rem_next = {rem_q, x_q[RadBits-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		fits     = rem_next >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == RootCntBits'(MagBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			if (fits) begin
				rem_q  <= (MagBits+1)'(rem_next - trial);
				root_q <= {root_q[MagBits-2:0], 1'b1};
			end else begin
				rem_q  <= (MagBits+1)'(rem_next);
				root_q <= {root_q[MagBits-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== hw/rtl/step_and_fall_detector.sv =====
// Top level of the step counter and fall detector.
// Usage:
//   Input channel (in_valid/in_stall) takes one time-stamped six-axis sample
//   per request. Output channel (out_valid/out_stall) returns one result per
//   sample: step count, step and fall flags and the acceleration magnitude.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle.
// Processing:
//   A sample is accepted only while the block is idle, so the next sample
//   waits until the previous result has been loaded into the output register.
//   A sample passes through seven squares in the shared squaring multiplier,
//   the last sum and done flag, the start and sixteen iterations of the square
//   root unit, the latching of the root and the decision state.
//   in_stall is high while a sample is being worked on.
// Reset:
//   arst_n clears the step count, the fall watch and the time marks and loads
//   the default thresholds; no result is pending afterwards.
// Stall:
//   A result waits in the output register while out_stall is high; the next
//   sample may already be in progress, but its result is held back until the
//   output register is free.
`default_nettype none
module step_and_fall_detector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] time_ms,
	input  wire logic [15:0] accel_x,
	input  wire logic [15:0] accel_y,
	input  wire logic [15:0] accel_z,
	input  wire logic [15:0] gyro_x,
	input  wire logic [15:0] gyro_y,
	input  wire logic [15:0] gyro_z,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      step_count,
	output logic             step_taken,
	output logic             fall_watch,
	output logic             fall_confirmed,
	output logic [15:0]      accel_magnitude
);
	import sfd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SQ   = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [15:0] gofs_x_q, gofs_y_q, gofs_z_q;
	logic [15:0] step_thr_q, step_gap_q, fall_acc_thr_q, fall_rate_thr_q, still_q;

	// detector state
	logic [MagBits:0]     prev_mag_q;
	logic [TimeBits-1:0]  last_step_q;
	logic [CountBits-1:0] steps_q;
	logic                 watch_q;
	logic [TimeBits-1:0]  still_start_q;

	// sample registers
	logic [TimeBits-1:0] time_q;
	sq_ops_t             ops_q;
	logic [MagBits-1:0]  mag_q;

	// output register
	logic                out_valid_q;
	logic [31:0]         out_count_q;
	logic                out_step_q, out_watch_q, out_conf_q;
	logic [MagBits-1:0]  out_mag_q;

	logic        accept;
	logic        sq_start;
	sq_res_t     sq_res;
	logic        rt_start;
	logic        rt_done;
	logic [MagBits-1:0] rt_root;
	logic        fin_go;

	// input operand preparation
	logic [OpndBits-1:0] abs_ax, abs_ay, abs_az, abs_gx, abs_gy, abs_gz;
	logic signed [16:0]  cor_x, cor_y, cor_z;

	// decision signals
	logic                step_now;
	logic                suspect;
	logic                watch_mid;
	logic [TimeBits-1:0] start_mid;
	logic                in_band;
	logic                confirm;
	logic                watch_n;
	logic [TimeBits-1:0] start_n;
	logic [CountBits-1:0] steps_n;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign sq_start = accept;
	assign rt_start = (state_q == ST_SQ) && sq_res.done;
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gofs_x_q        <= '0;
			gofs_y_q        <= '0;
			gofs_z_q        <= '0;
			step_thr_q      <= StepThrRst;
			step_gap_q      <= StepGapRst;
			fall_acc_thr_q  <= FallAccThrRst;
			fall_rate_thr_q <= FallRateThrRst;
			still_q         <= StillRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GYRO_OFS_X:   gofs_x_q        <= cfg_data;
				REG_GYRO_OFS_Y:   gofs_y_q        <= cfg_data;
				REG_GYRO_OFS_Z:   gofs_z_q        <= cfg_data;
				REG_STEP_THR:     step_thr_q      <= cfg_data;
				REG_STEP_GAP:     step_gap_q      <= cfg_data;
				REG_FALL_ACC_THR: fall_acc_thr_q  <= cfg_data;
				REG_FALL_RATE:    fall_rate_thr_q <= cfg_data;
				REG_STILL:        still_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// absolute values; gyro correction is exact in 17 bits
	always_comb begin
		abs_ax = accel_x[15] ? OpndBits'(~accel_x + 16'd1) : accel_x;
		abs_ay = accel_y[15] ? OpndBits'(~accel_y + 16'd1) : accel_y;
		abs_az = accel_z[15] ? OpndBits'(~accel_z + 16'd1) : accel_z;
		cor_x  = 17'(signed'(gyro_x)) - 17'(gofs_x_q);
		cor_y  = 17'(signed'(gyro_y)) - 17'(gofs_y_q);
		cor_z  = 17'(signed'(gyro_z)) - 17'(gofs_z_q);
		abs_gx = cor_x[16] ? OpndBits'(-cor_x) : cor_x[15:0];
		abs_gy = cor_y[16] ? OpndBits'(-cor_y) : cor_y[15:0];
		abs_gz = cor_z[16] ? OpndBits'(-cor_z) : cor_z[15:0];
	end

	// capture the sample
	always_ff @(posedge clk) begin
		if (accept) begin
			time_q <= TimeBits'(time_ms);
			ops_q  <= {fall_rate_thr_q, abs_gz, abs_gy, abs_gx, abs_az, abs_ay, abs_ax};
		end
		if (rt_done)
			mag_q <= rt_root;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept)        state_q <= ST_SQ;
				ST_SQ:   if (sq_res.done)   state_q <= ST_ROOT;
				ST_ROOT: if (rt_done)       state_q <= ST_FIN;
				ST_FIN:  if (fin_go)        state_q <= ST_IDLE;
				default:                    state_q <= ST_IDLE;
			endcase
		end
	end

	sfd_sqacc u_sqacc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.ops    (ops_q),
		.res    (sq_res)
	);

	sfd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand (sq_res.mag_sq),
		.done     (rt_done),
		.root     (rt_root)
	);

	// step and fall decisions
	always_comb begin
		step_now = ({1'b0, mag_q} > prev_mag_q + RiseLimit) && (mag_q > step_thr_q)
			&& (TimeBits'(time_q - last_step_q) > TimeBits'(step_gap_q));
		steps_n  = step_now ? steps_q + 1'b1 : steps_q;

		suspect   = !watch_q && (mag_q > fall_acc_thr_q)
			&& (sq_res.rate_sq > RateBits'(sq_res.rate_lim));
		watch_mid = watch_q || suspect;
		start_mid = suspect ? time_q : still_start_q;
		in_band   = (mag_q >= BandLow) && (mag_q <= BandHigh);

		watch_n = watch_mid;
		start_n = start_mid;
		confirm = 1'b0;
		if (watch_mid) begin
			if (in_band) begin
				if (TimeBits'(time_q - start_mid) >= TimeBits'(still_q)) begin
					watch_n = 1'b0;
					confirm = 1'b1;
				end
			end else begin
				start_n = time_q;
			end
		end
	end

	// detector state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mag_q    <= '0;
			last_step_q   <= '0;
			steps_q       <= '0;
			watch_q       <= 1'b0;
			still_start_q <= '0;
		end else if (fin_go) begin
			prev_mag_q    <= {1'b0, mag_q};
			if (step_now)
				last_step_q <= time_q;
			steps_q       <= steps_n;
			watch_q       <= watch_n;
			still_start_q <= start_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_count_q <= 32'(steps_n);
			out_step_q  <= step_now;
			out_watch_q <= watch_n;
			out_conf_q  <= confirm;
			out_mag_q   <= mag_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign step_count      = out_count_q;
	assign step_taken      = out_step_q;
	assign fall_watch      = out_watch_q;
	assign fall_confirmed  = out_conf_q;
	assign accel_magnitude = out_mag_q;

	// checks
	a_root_in_root_state: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> (state_q == ST_ROOT))
		else $error("root done outside root state");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside decision state");

	a_step_above_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_step_q) |-> (out_mag_q > step_thr_q))
		else $error("step counted below threshold");

	a_confirm_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_conf_q) |->
			((out_mag_q >= BandLow) && (out_mag_q <= BandHigh) && !out_watch_q))
		else $error("fall confirmed outside stillness band");

endmodule
`default_nettype wire

// ===== sim/tb_step_and_fall_detector.sv =====
// Self-checking testbench for the step counter and fall detector.
module tb_step_and_fall_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import sfd_pkg::*;

	// Magnitude limits in raw accel LSB: 0.3 g rise, 0.8 g .. 1.2 g stillness band
	localparam int StepRise    = 4915;
	localparam int StillLo     = 13108;
	localparam int StillHi     = 19660;
	localparam int CycleLimit  = 600000;
	localparam int DrainCycles = 40;

	typedef struct {
		logic [31:0]        t;
		logic signed [15:0] ax, ay, az;
		logic signed [15:0] gx, gy, gz;
	} imu_sample_t;

	typedef struct {
		logic [31:0] step_count;
		logic        step_taken;
		logic        fall_watch;
		logic        fall_confirmed;
		logic [15:0] accel_magnitude;
	} motion_result_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_reg_t    cfg_index = REG_GYRO_OFS_X;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] time_ms = '0;
	logic [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] step_count;
	logic        step_taken;
	logic        fall_watch;
	logic        fall_confirmed;
	logic [15:0] accel_magnitude;

	// Model copy of the registers, at their power-on values
	int          ofs_x = 0, ofs_y = 0, ofs_z = 0;
	int unsigned step_thr = 19661, step_gap = 350;
	int unsigned fall_acc = 52429, fall_rate = 39300, still_ms = 2000;

	// Model copy of the detector state
	int unsigned prev_mag = 0;
	logic [31:0] last_step_ms = '0;
	logic [31:0] step_total = '0;
	logic        watching = 1'b0;
	logic [31:0] still_start_ms = '0;

	motion_result_t expected_motion[$];
	int             mismatches = 0;
	int             cycle_count = 0;
	int             burst_left = 0;
	logic [31:0]    clock_ms = '0;

	step_and_fall_detector dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.time_ms         (time_ms),
		.accel_x         (accel_x),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.gyro_x          (gyro_x),
		.gyro_y          (gyro_y),
		.gyro_z          (gyro_z),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.step_count      (step_count),
		.step_taken      (step_taken),
		.fall_watch      (fall_watch),
		.fall_confirmed  (fall_confirmed),
		.accel_magnitude (accel_magnitude)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bit-serial floor square root
	function automatic int unsigned floor_root(logic [31:0] x);
		logic [31:0] rem, root, probe;
		rem = x;
		root = '0;
		probe = 32'h4000_0000;
		while (probe > rem)
			probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// Step and fall decision for one sample; advances the model state
	function automatic motion_result_t predict_motion(imu_sample_t s);
		motion_result_t r;
		longint         mag_sq, rate_sq, rate_lim, cx, cy, cz;
		int unsigned    mag;
		logic [31:0]    since_step, since_still;
		mag_sq = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
		mag = floor_root(mag_sq[31:0]);
		// gyro correction is exact, 17 bits wide
		cx = longint'(s.gx) - ofs_x;
		cy = longint'(s.gy) - ofs_y;
		cz = longint'(s.gz) - ofs_z;
		rate_sq = cx * cx + cy * cy + cz * cz;
		rate_lim = longint'(fall_rate) * longint'(fall_rate);

		since_step = s.t - last_step_ms;
		r.step_taken = (mag > prev_mag + StepRise) && (mag > step_thr) &&
			(since_step > step_gap);
		if (r.step_taken) begin
			step_total = step_total + 1'b1;
			last_step_ms = s.t;
		end
		prev_mag = mag;

		// a new suspicion never restarts a watch already running
		if (!watching && mag > fall_acc && rate_sq > rate_lim) begin
			watching = 1'b1;
			still_start_ms = s.t;
		end
		r.fall_confirmed = 1'b0;
		if (watching) begin
			since_still = s.t - still_start_ms;
			if (mag >= StillLo && mag <= StillHi) begin
				if (since_still >= still_ms) begin
					watching = 1'b0;
					r.fall_confirmed = 1'b1;
				end
			end else begin
				still_start_ms = s.t;
			end
		end

		r.step_count = step_total;
		r.fall_watch = watching;
		r.accel_magnitude = mag[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Result checker: each accepted result against the oldest prediction
	always @(posedge clk) begin
		motion_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_motion.size() == 0) begin
				report_mismatch("result with no sample pending", step_count, '0);
			end else begin
				want = expected_motion.pop_front();
				if (step_count !== want.step_count)
					report_mismatch("step_count", step_count, want.step_count);
				if (step_taken !== want.step_taken)
					report_mismatch("step_taken", step_taken, want.step_taken);
				if (fall_watch !== want.fall_watch)
					report_mismatch("fall_watch", fall_watch, want.fall_watch);
				if (fall_confirmed !== want.fall_confirmed)
					report_mismatch("fall_confirmed", fall_confirmed, want.fall_confirmed);
				if (accel_magnitude !== want.accel_magnitude)
					report_mismatch("accel_magnitude", accel_magnitude, want.accel_magnitude);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Output backpressure: a random stall mode is held for a random span, then another is picked
	initial begin
		stall_mode_t mode;
		int          span;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(50, 400);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
					default:     out_stall <= ($urandom_range(0, 19) == 0) ? !out_stall : out_stall;
				endcase
			end
		end
	end

	function automatic logic signed [15:0] clip16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] rand_span(int span);
		int r;
		r = $urandom_range(0, 2 * span);
		return clip16(r - span);
	endfunction

	function automatic imu_sample_t sample_at(logic [31:0] t, int ax, int ay, int az,
			int gx, int gy, int gz);
		imu_sample_t s;
		s.t = t;
		s.ax = clip16(ax);
		s.ay = clip16(ay);
		s.az = clip16(az);
		s.gx = clip16(gx);
		s.gy = clip16(gy);
		s.gz = clip16(gz);
		return s;
	endfunction

	// Mostly vertical acceleration of about the target size, some sideways wobble
	function automatic imu_sample_t shaped(logic [31:0] t, int target, int wobble, int gyro_span);
		imu_sample_t s;
		s.t = t;
		s.ax = rand_span(wobble);
		s.ay = rand_span(wobble);
		s.az = clip16(($urandom_range(0, 1) == 0) ? target : -target);
		s.gx = rand_span(gyro_span);
		s.gy = rand_span(gyro_span);
		s.gz = rand_span(gyro_span);
		return s;
	endfunction

	// Hard hit on all three axes with arbitrary rotation
	function automatic imu_sample_t impact_sample(logic [31:0] t);
		imu_sample_t s;
		int          a[3];
		foreach (a[i]) begin
			a[i] = $urandom_range(24000, 32768);
			if ($urandom_range(0, 1) == 0)
				a[i] = -a[i];
		end
		s = sample_at(t, a[0], a[1], a[2], 0, 0, 0);
		s.gx = 16'($urandom);
		s.gy = 16'($urandom);
		s.gz = 16'($urandom);
		return s;
	endfunction

	function automatic imu_sample_t random_sample(logic [31:0] t);
		imu_sample_t s;
		s.t = t;
		s.ax = 16'($urandom);
		s.ay = 16'($urandom);
		s.az = 16'($urandom);
		s.gx = 16'($urandom);
		s.gy = 16'($urandom);
		s.gz = 16'($urandom);
		return s;
	endfunction

	// Sample clock: usually forward, now and then backward or an arbitrary jump
	function automatic logic [31:0] advance_clock(int lo, int hi);
		int pick;
		pick = $urandom_range(0, 49);
		if (pick == 0)
			clock_ms = clock_ms - $urandom_range(0, 1000);
		else if (pick == 1)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(lo, hi);
		return clock_ms;
	endfunction

	function automatic int extreme16();
		int pick;
		pick = $urandom_range(0, 2);
		if (pick == 0)
			return -32768;
		if (pick == 1)
			return 32767;
		return rand_span(32768);
	endfunction

	// One sample request; the sender runs in bursts with random gaps between
	task automatic send_sample(imu_sample_t s);
		in_valid <= 1'b1;
		time_ms <= s.t;
		accel_x <= s.ax;
		accel_y <= s.ay;
		accel_z <= s.az;
		gyro_x <= s.gx;
		gyro_y <= s.gy;
		gyro_z <= s.gz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_motion.push_back(predict_motion(s));
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 99) == 0) begin
				// hold off until the block has handed back everything
				while (expected_motion.size() != 0)
					@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic put_reg(cfg_reg_t r, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_GYRO_OFS_X:   ofs_x = $signed(v);
			REG_GYRO_OFS_Y:   ofs_y = $signed(v);
			REG_GYRO_OFS_Z:   ofs_z = $signed(v);
			REG_STEP_THR:     step_thr = v;
			REG_STEP_GAP:     step_gap = v;
			REG_FALL_ACC_THR: fall_acc = v;
			REG_FALL_RATE:    fall_rate = v;
			REG_STILL:        still_ms = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Writes every register; only called with nothing in flight
	task automatic set_config(int ox, int oy, int oz, int thr, int gap, int acc, int rate,
			int still);
		put_reg(REG_GYRO_OFS_X, ox[15:0]);
		put_reg(REG_GYRO_OFS_Y, oy[15:0]);
		put_reg(REG_GYRO_OFS_Z, oz[15:0]);
		put_reg(REG_STEP_THR, thr[15:0]);
		put_reg(REG_STEP_GAP, gap[15:0]);
		put_reg(REG_FALL_ACC_THR, acc[15:0]);
		put_reg(REG_FALL_RATE, rate[15:0]);
		put_reg(REG_STILL, still[15:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		// power-on settings: zero input, both accel extremes, fall then recovery
		send_sample(sample_at(32'd0, 0, 0, 0, 0, 0, 0));
		send_sample(sample_at(32'd1000, -32768, -32768, -32768, 32767, 32767, 32767));
		// second suspicion while watching, out of band so the timer restarts
		send_sample(sample_at(32'd1100, 32767, 32767, 32767, -32768, -32768, -32768));
		send_sample(sample_at(32'd1200, 0, 0, 16384, 0, 0, 0));
		send_sample(sample_at(32'd3200, 0, 0, 16384, 0, 0, 0));
		// rate just under, then over, the default limit
		send_sample(sample_at(32'd3400, -32768, -32768, -32768, -32768, 0, 0));
		send_sample(sample_at(32'd3500, -32768, -32768, -32768, -32768, -32768, 0));
		// band edges: low edge holds, one below restarts, high edge confirms
		send_sample(sample_at(32'd3600, 0, 0, 13108, 0, 0, 0));
		send_sample(sample_at(32'd3700, 0, 0, 13107, 0, 0, 0));
		send_sample(sample_at(32'd5700, 0, 0, 19660, 0, 0, 0));
		send_sample(sample_at(32'd5800, 0, 0, 19661, 0, 0, 0));
		// steps across timestamp wrap, then time going backwards
		send_sample(sample_at(32'hFFFF_FE00, 0, 0, -32768, 0, 0, 0));
		send_sample(sample_at(32'hFFFF_FF00, 0, 0, 0, 0, 0, 0));
		send_sample(sample_at(32'h0000_0100, 0, 0, 32767, 0, 0, 0));
		send_sample(sample_at(32'h0000_0050, 0, 0, 0, 0, 0, 0));
		send_sample(sample_at(32'h0000_0060, 0, 0, 32767, 0, 0, 0));
		wait_for_results();

		// lowest thresholds, gyro bias pushing correction to the 17-bit ends
		set_config(-32768, 32767, -32768, 0, 0, 0, 0, 0);
		send_sample(sample_at(32'd10, 0, 0, 0, 0, 0, 0));
		send_sample(sample_at(32'd20, 0, 0, 4916, 32767, -32768, 32767));
		send_sample(sample_at(32'd20, 0, 0, 16384, 0, 0, 0));
		wait_for_results();

		// highest thresholds, opposite bias
		set_config(32767, -32768, 32767, 65535, 65535, 65535, 65535, 65535);
		send_sample(sample_at(32'd30, -32768, -32768, -32768, -32768, 32767, -32768));
		send_sample(sample_at(32'd40, 0, 0, 0, 0, 0, 0));
		wait_for_results();
	endtask

	// Walking: rest and peak samples alternate, with some noise mixed in
	task automatic test_step_sequences();
		repeat (2) begin
			set_config(rand_span(500), rand_span(500), rand_span(500),
				$urandom_range(16384, 32768), $urandom_range(0, 500),
				$urandom_range(40000, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 3000));
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_sample(random_sample(advance_clock(0, 1000)));
				else if (n % 2 == 1)
					send_sample(shaped(advance_clock(30, 300), $urandom_range(20000, 45000),
						4000, 3000));
				else
					send_sample(shaped(advance_clock(30, 300), $urandom_range(12000, 18000),
						2000, 800));
			end
			wait_for_results();
		end
	endtask

	// Falls: an impact, then mostly in-band samples until stillness is confirmed
	task automatic test_fall_sequences();
		int edges[4] = '{13107, 13108, 19660, 19661};
		int sent;
		int hi_step;
		int pick;
		for (int round = 0; round < 3; round++) begin
			set_config(rand_span(2000), rand_span(2000), rand_span(2000),
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(30000, 50000), $urandom_range(5000, 40000),
				(round == 2) ? 2000 : $urandom_range(0, 800));
			if (round == 0)
				clock_ms = 32'hFFFF_F800;
			hi_step = (round == 2) ? 500 : 200;
			sent = 0;
			while (sent < 150) begin
				send_sample(impact_sample(advance_clock(10, hi_step)));
				sent++;
				repeat ($urandom_range(2, 15)) begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						send_sample(shaped(advance_clock(10, hi_step),
							($urandom_range(0, 1) == 0) ? $urandom_range(2000, 13000) :
							$urandom_range(19700, 40000), 1000, 500));
					else if (pick == 1)
						send_sample(impact_sample(advance_clock(10, hi_step)));
					else if (pick == 2)
						send_sample(shaped(advance_clock(10, hi_step),
							edges[$urandom_range(0, 3)], 0, 500));
					else
						send_sample(shaped(advance_clock(10, hi_step),
							$urandom_range(StillLo, StillHi), 0, 500));
					sent++;
				end
			end
			wait_for_results();
		end
	endtask

	// Gyro bias at the ends of its range against gyro readings of opposite sign
	task automatic test_offset_extremes();
		int          ox, oy, oz;
		imu_sample_t s;
		repeat (2) begin
			ox = extreme16();
			oy = extreme16();
			oz = extreme16();
			set_config(ox, oy, oz, $urandom_range(0, 65535), $urandom_range(0, 1000),
				($urandom_range(0, 1) == 0) ? 0 : $urandom_range(20000, 56000),
				($urandom_range(0, 2) == 0) ? 0 :
				(($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(0, 65535)),
				$urandom_range(0, 500));
			repeat (50) begin
				if ($urandom_range(0, 1) == 0)
					s = impact_sample(advance_clock(10, 200));
				else
					s = shaped(advance_clock(10, 200), $urandom_range(StillLo, StillHi), 0, 30000);
				if ($urandom_range(0, 1) == 0) begin
					s.gx = (ox < 0) ? 16'sh7fff : 16'sh8000;
					s.gy = (oy < 0) ? 16'sh7fff : 16'sh8000;
					s.gz = (oz < 0) ? 16'sh7fff : 16'sh8000;
				end
				send_sample(s);
			end
			wait_for_results();
		end
	endtask

	// Unshaped samples under random settings, then under the power-on settings
	task automatic test_random_samples();
		for (int round = 0; round < 2; round++) begin
			if (round == 0)
				set_config(rand_span(32768), rand_span(32768), rand_span(32768),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			else
				set_config(0, 0, 0, 19661, 350, 52429, 39300, 2000);
			repeat (150) begin
				if ($urandom_range(0, 2) == 0)
					send_sample(random_sample($urandom));
				else
					send_sample(random_sample(advance_clock(0, 5000)));
			end
			wait_for_results();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_step_sequences();
		test_fall_sequences();
		test_offset_extremes();
		test_random_samples();

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (expected_motion.size() != 0)
			report_mismatch("results never returned", expected_motion.size(), '0);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
